@@ design/bbmc_pkg.sv @@
// shared types, constants and lookup for the button brightness mode controller
package bbmc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_SHORT_PRESS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE_MIN    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ANIM_PERIOD = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FULL_DELAY  = 3'd4;

  localparam logic [7:0] SHORT_PRESS_RST = 8'd8;
  localparam logic [7:0] LONG_PRESS_RST  = 8'd200;
  localparam logic [7:0] IDLE_MIN_RST    = 8'd15;
  localparam logic [7:0] ANIM_PERIOD_RST = 8'd50;
  localparam logic [7:0] FULL_DELAY_RST  = 8'd250;

  localparam logic [6:0] TICKS_PER_SEC = 7'd100;
  localparam logic [5:0] SEC_PER_MIN   = 6'd60;
  localparam logic [2:0] LEVEL_COUNT   = 3'd7;
  localparam logic [2:0] LAST_PHASE    = 3'd6;
  localparam logic [5:0] BAR_ALL       = 6'h3f;
  localparam logic [7:0] MIN_SAT       = 8'd255;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_ev_t;

  typedef struct packed {
    logic [7:0] short_press_ticks;
    logic [7:0] long_press_ticks;
    logic [7:0] idle_minutes;
    logic [7:0] anim_period;
    logic [7:0] full_delay;
  } cfg_t;

  typedef struct packed {
    logic key_pressed;
    logic charger_present;
    logic voltage_flag;
  } in_item_t;

  typedef struct packed {
    logic [2:0] brightness_step;
    logic [5:0] duty_level;
    logic [5:0] led_bar;
    logic       status_led;
    logic [1:0] press_event;
    logic       sleep_request;
  } out_item_t;

  typedef struct packed {
    logic [7:0] hold_count;
    logic       long_reported;
    logic [2:0] work_level;
    logic [5:0] lamp_duty;
    logic [6:0] second_ticks;
    logic [5:0] minute_seconds;
    logic [7:0] lit_minutes;
    logic [7:0] anim_ticks;
    logic [2:0] anim_phase;
    logic [7:0] full_ticks;
    logic [5:0] led_bits;
    logic       status_bit;
  } state_t;

  function automatic logic [5:0] duty_lookup(input logic [2:0] lvl);
    logic [5:0] d;
    case (lvl)
      3'd1:    d = 6'd9;
      3'd2:    d = 6'd11;
      3'd3:    d = 6'd14;
      3'd4:    d = 6'd19;
      3'd5:    d = 6'd35;
      3'd6:    d = 6'd45;
      default: d = 6'd0;
    endcase
    return d;
  endfunction

  function automatic logic [5:0] bar_bit(input logic [2:0] lvl);
    logic [5:0] b;
    case (lvl)
      3'd1:    b = 6'h01;
      3'd2:    b = 6'h02;
      3'd3:    b = 6'h04;
      3'd4:    b = 6'h08;
      3'd5:    b = 6'h10;
      3'd6:    b = 6'h20;
      default: b = 6'h00;
    endcase
    return b;
  endfunction

endpackage

@@ design/bbmc_core.sv @@
// per-tick state update and result computation with the state registers
module bbmc_core import bbmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  cfg_t      cfg,
  input  in_item_t  item,
  output out_item_t result
);

  state_t st_r;
  state_t st_nxt;

  always_comb begin
    state_t    s;
    press_ev_t ev;
    logic      slp;
    logic [8:0] c9;
    logic [7:0] sec_n;
    logic [6:0] mins_n;

    s      = st_r;
    ev     = EV_NONE;
    slp    = 1'b0;
    c9     = '0;
    sec_n  = '0;
    mins_n = '0;

    if (!item.charger_present) begin
      if (item.key_pressed) begin
        c9 = {1'b0, s.hold_count} + 9'd1;
        if (c9 >= {1'b0, cfg.long_press_ticks}) begin
          s.hold_count = cfg.long_press_ticks;
          if (!s.long_reported) begin
            s.long_reported = 1'b1;
            ev = EV_LONG;
          end
        end else begin
          s.hold_count = c9[7:0];
        end
      end else begin
        if (s.hold_count >= cfg.long_press_ticks) begin
          s.long_reported = 1'b0;
        end else if (s.hold_count >= cfg.short_press_ticks) begin
          ev = EV_SHORT;
        end
        s.hold_count = '0;
      end

      if (ev == EV_SHORT) begin
        if (s.work_level + 3'd1 >= LEVEL_COUNT) begin
          s.work_level = '0;
        end else begin
          s.work_level = s.work_level + 3'd1;
        end
      end else if (ev == EV_LONG) begin
        s.work_level = '0;
      end

      s.lamp_duty = duty_lookup(s.work_level);
      if (s.work_level == 3'd0) begin
        s.led_bits   = '0;
        s.status_bit = 1'b0;
        if (s.hold_count == 8'd0) begin
          s.lit_minutes = '0;
          s.lamp_duty   = '0;
          slp = 1'b1;
        end
      end else begin
        s.led_bits = s.led_bits | bar_bit(s.work_level);
      end
    end else begin
      s.lamp_duty   = '0;
      s.work_level  = '0;
      s.lit_minutes = '0;
      if (item.voltage_flag) begin
        c9 = {1'b0, s.anim_ticks} + 9'd1;
        s.status_bit = 1'b1;
        if (c9 > {1'b0, cfg.anim_period}) begin
          c9 = '0;
          if (s.anim_phase >= LAST_PHASE) begin
            s.anim_phase = '0;
          end else begin
            s.anim_phase = s.anim_phase + 3'd1;
          end
        end
        s.anim_ticks = c9[7:0];
        s.full_ticks = '0;
      end else begin
        c9 = {1'b0, s.full_ticks} + 9'd1;
        if (c9 > {1'b0, cfg.full_delay}) begin
          s.status_bit = 1'b0;
          c9 = {1'b0, cfg.full_delay};
          s.led_bits = BAR_ALL;
        end
        s.full_ticks = c9[7:0];
      end
      if (s.anim_phase == 3'd0) begin
        s.led_bits = '0;
      end else begin
        s.led_bits = s.led_bits | bar_bit(s.anim_phase);
      end
    end

    if (s.work_level != 3'd0) begin
      sec_n = {1'b0, s.second_ticks} + 8'd1;
      if (sec_n >= {1'b0, TICKS_PER_SEC}) begin
        s.second_ticks = '0;
        mins_n = {1'b0, s.minute_seconds} + 7'd1;
        if (mins_n >= {1'b0, SEC_PER_MIN}) begin
          s.minute_seconds = '0;
          if (s.lit_minutes != MIN_SAT) begin
            s.lit_minutes = s.lit_minutes + 8'd1;
          end
        end else begin
          s.minute_seconds = mins_n[5:0];
        end
      end else begin
        s.second_ticks = sec_n[6:0];
      end
      if (s.lit_minutes >= cfg.idle_minutes && s.hold_count == 8'd0) begin
        s.status_bit  = 1'b0;
        s.led_bits    = '0;
        s.lit_minutes = '0;
        s.work_level  = '0;
        s.lamp_duty   = '0;
        slp = 1'b1;
      end
    end

    st_nxt = s;
    result.brightness_step = s.work_level;
    result.duty_level      = s.lamp_duty;
    result.led_bar         = s.led_bits;
    result.status_led      = s.status_bit;
    result.press_event     = ev;
    result.sleep_request   = slp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ design/button_brightness_mode_controller.sv @@
// top level: handshakes, configuration registers, input and result registers
// One input transaction per 10 ms tick gives one result transaction. An item
// is held in the input register and is then moved, with the state update,
// into the result register; a new item can be taken every cycle unless the
// result register is stalled, so the sustained rate is one item per clock
// while out_stall is low. The configuration port is always ready and takes a
// write whenever cfg_valid is high; writes to an index beyond the five registers are dropped.
module button_brightness_mode_controller import bbmc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data
);

  cfg_t      cfg_r;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t step_result;
  logic      out_free;
  logic      move;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign move      = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_press_ticks <= SHORT_PRESS_RST;
      cfg_r.long_press_ticks  <= LONG_PRESS_RST;
      cfg_r.idle_minutes      <= IDLE_MIN_RST;
      cfg_r.anim_period       <= ANIM_PERIOD_RST;
      cfg_r.full_delay        <= FULL_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHORT_PRESS: cfg_r.short_press_ticks <= cfg_data;
        REG_LONG_PRESS:  cfg_r.long_press_ticks  <= cfg_data;
        REG_IDLE_MIN:    cfg_r.idle_minutes      <= cfg_data;
        REG_ANIM_PERIOD: cfg_r.anim_period       <= cfg_data;
        REG_FULL_DELAY:  cfg_r.full_delay        <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  bbmc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (move),
    .cfg     (cfg_r),
    .item    (in_item_r),
    .result  (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_item_r <= step_result;
    end
  end

endmodule
